>>> rtl/sitda_pkg.sv
// sitda_pkg: shared constants and types for the signed integer to decimal text block
// used by sitda_dabble, sitda_emit, signed_int_to_decimal_ascii and sitda_check
package sitda_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_W        = 64;
    localparam int DIGITS      = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W       = DIGITS * 4;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int LEFT_W      = $clog2(DIGITS);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIGIT_ADJ     = 4'd3;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } conv_t;

endpackage

>>> rtl/sitda_dabble.sv
// sitda_dabble: bit-serial binary to bcd converter, one shift-and-adjust step per cycle
// depends on sitda_pkg
module sitda_dabble (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sitda_pkg::IN_W-1:0]  value,
    input  logic                        take,
    output logic                        busy,
    output sitda_pkg::conv_t            conv
);
    import sitda_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] raw;
    logic [BCD_W-1:0]       adj;

    assign raw = value[VALUE_WIDTH-1:0];

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= DIGIT_ADJ_MIN)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + DIGIT_ADJ;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next = raw[VALUE_WIDTH-1];
                    if (raw[VALUE_WIDTH-1])
                    begin
                        bin_next = ~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        bin_next = raw;
                    end
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            bcd_reg   <= '0;
            bin_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bcd_reg   <= bcd_next;
            bin_reg   <= bin_next;
            neg_reg   <= neg_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign conv.valid = (state_reg == S_HOLD);
    assign conv.neg   = neg_reg;
    assign conv.bcd   = bcd_reg;

endmodule

>>> rtl/sitda_emit.sv
// sitda_emit: character sequencer, drops leading zeros and sends sign and digits
// depends on sitda_pkg
module sitda_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  sitda_pkg::conv_t conv,
    output logic             take,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       text_char,
    output logic             last
);
    import sitda_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_SIGN,
        E_DIGIT
    } state_t;

    state_t            state_reg, state_next;
    logic [BCD_W-1:0]  digits_reg, digits_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic [3:0]        top_digit;
    logic              slot_free;

    assign top_digit = digits_reg[BCD_W-1 -: 4];
    assign slot_free = !out_valid_reg || !out_stall;
    assign take      = (state_reg == E_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        left_next      = left_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (conv.valid)
                begin
                    digits_next = conv.bcd;
                    neg_next    = conv.neg;
                    left_next   = LEFT_W'(DIGITS - 1);
                    state_next  = E_SKIP;
                end
            end
            E_SKIP:
            begin
                if (top_digit == 4'd0 && left_reg != '0)
                begin
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    left_next   = left_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = E_SIGN;
                end
                else
                begin
                    state_next = E_DIGIT;
                end
            end
            E_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = E_DIGIT;
                end
            end
            E_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {4'd0, top_digit};
                    last_next      = (left_reg == '0);
                    digits_next    = {digits_reg[BCD_W-5:0], 4'd0};
                    left_next      = left_reg - 1'b1;
                    if (left_reg == '0)
                    begin
                        state_next = E_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            digits_reg    <= '0;
            left_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digits_reg    <= digits_next;
            left_reg      <= left_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: top level, signed integer in, decimal ascii beats out
// depends on sitda_pkg, sitda_dabble and sitda_emit
//
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_stall       value [63:0] signed
//  out      output     out_valid / out_stall     text_char [7:0], last
//
//  a value is loaded and then converted in the shift-and-adjust loop; in_stall
//  stays high until the bcd result passes to the character sequencer, which
//  drops leading zeros and then sends one beat per cycle while out_stall is low
//  (sign first when negative, at most 20 beats). out_stall holds the current beat
//  and the sequencer; the next value may convert meanwhile. rst_n clears all
//  control state asynchronously
module signed_int_to_decimal_ascii (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sitda_pkg::IN_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        text_char,
    output logic                              last
);
    import sitda_pkg::*;

    conv_t conv;
    logic  busy;
    logic  take;
    logic  start;

    assign in_stall = busy;
    assign start    = in_valid && !busy;

    sitda_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (value),
        .take  (take),
        .busy  (busy),
        .conv  (conv)
    );

    sitda_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv      (conv),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last      (last)
    );

endmodule

>>> rtl/sitda_check.sv
// sitda_check: port-level checks for signed_int_to_decimal_ascii, bound to the top level
// depends on sitda_pkg
module sitda_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] text_char,
    input logic       last
);
    import sitda_pkg::*;

    // a held beat does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(last))
        else $error("output beat changed while stalled");

    // an accepted value keeps the input stalled while it converts
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted during conversion");

    // only a sign or a decimal digit is sent
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_char == CHAR_MINUS) ||
                      (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 8'd9))
        else $error("illegal character on output");

    // a sign is always followed by at least one digit
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (text_char == CHAR_MINUS) |-> !last)
        else $error("sign flagged as final beat");

endmodule

bind signed_int_to_decimal_ascii sitda_check u_sitda_check (.*);
